[sv/swmf_pkg.sv]
// ----------------------------------------------------------------------------
// swmf_pkg
// shared widths, defaults and reset values for the running median filter
// ----------------------------------------------------------------------------
package swmf_pkg;

	// sample and median width
	localparam int SAMPLE_W = 16;

	// window size register width and reset value
	localparam int WSIZE_W = 5;
	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd3;

	// default store depth
	localparam int MAX_WINDOW_DEF = 16;

endpackage

[sv/swmf_window_ram.sv]
// ----------------------------------------------------------------------------
// swmf_window_ram
// sample store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module swmf_window_ram
	import swmf_pkg::*;
#(
	parameter int DEPTH = MAX_WINDOW_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic signed [SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic signed [SAMPLE_W-1:0] rdata
);

	logic signed [SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/sliding_window_median_filter_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_filter_core
// running median over the most recent samples of a signed stream
// ----------------------------------------------------------------------------
// Each accepted sample is appended to a circular store of MAX_WINDOW entries;
// the oldest samples are then dropped until at most window_size remain
// (0 acts as 1, values above MAX_WINDOW saturate), and one median item is
// produced. An even count gives the mean of the two middle values, rounded
// toward zero. The median is found by rank counting: every window entry in
// turn is compared against all entries by one shared signed comparator fed
// from the single read port of the store. The input is stalled until the
// median is stored in the output register; a finished median waits there,
// and the next sample may be accepted while it does. window_size is written
// only while the filter is idle.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_core
	import swmf_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// sample channel
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	// median channel
	output logic                       median_valid,
	input  logic                       median_stall,
	output logic signed [SAMPLE_W-1:0] median,
	// window size register write
	input  logic                       window_size_valid,
	output logic                       window_size_ready,
	input  logic [WSIZE_W-1:0]         window_size
);

	// store address width and sample count width
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	// common width to compare the register against the store depth
	localparam int LW = (CW > WSIZE_W) ? CW : WSIZE_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WINDOW);
	localparam logic [CW:0]   MAX_EXT = (CW+1)'(MAX_WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_LOAD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [WSIZE_W-1:0]         wsize_q;
	logic [CW-1:0]              fill_q;
	logic [AW-1:0]              oldest_q;
	logic [CW-1:0]              cand_idx_q;   // candidate under test
	logic [CW-1:0]              scan_idx_q;   // entry whose data is on rdata
	logic [CW-1:0]              less_q;
	logic [CW-1:0]              leq_q;
	logic signed [SAMPLE_W-1:0] cand_q;
	logic signed [SAMPLE_W-1:0] lo_q;
	logic signed [SAMPLE_W-1:0] hi_q;
	logic signed [SAMPLE_W-1:0] median_q;
	logic                       median_valid_q;

	// wrap a sum below twice the depth back into the store
	function automatic logic [AW-1:0] wrap_addr(input logic [CW:0] x);
		logic [CW:0] r;
		r = (x >= MAX_EXT) ? (x - MAX_EXT) : x;
		return r[AW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// window bookkeeping at sample accept
	// ------------------------------------------------------------------
	logic              sample_acc;
	logic [LW-1:0]     wsize_ext;
	logic [CW-1:0]     limit;
	logic              full;
	logic [AW-1:0]     wr_addr;
	logic [CW-1:0]     fill_app;
	logic [AW-1:0]     oldest_app;
	logic [CW-1:0]     drop;
	logic [CW-1:0]     fill_nxt;
	logic [AW-1:0]     oldest_nxt;

	assign sample_acc = sample_valid && !sample_stall;
	assign wsize_ext  = LW'(wsize_q);

	always_comb begin
		// clamp the configured size into 1..MAX_WINDOW
		priority if (wsize_q == '0) begin
			limit = CW'(1);
		end else if (wsize_ext > LW'(MAX_WINDOW)) begin
			limit = MAX_CNT;
		end else begin
			limit = wsize_ext[CW-1:0];
		end

		full = (fill_q == MAX_CNT);
		if (full) begin
			// overwrite the oldest entry
			wr_addr    = oldest_q;
			fill_app   = MAX_CNT;
			oldest_app = wrap_addr((CW+1)'(oldest_q) + (CW+1)'(1));
		end else begin
			wr_addr    = wrap_addr((CW+1)'(oldest_q) + (CW+1)'(fill_q));
			fill_app   = fill_q + CW'(1);
			oldest_app = oldest_q;
		end

		// drop all surplus oldest entries at once
		if (fill_app > limit) begin
			drop       = fill_app - limit;
			fill_nxt   = limit;
			oldest_nxt = wrap_addr((CW+1)'(oldest_app) + (CW+1)'(drop));
		end else begin
			drop       = '0;
			fill_nxt   = fill_app;
			oldest_nxt = oldest_app;
		end
	end

	// ------------------------------------------------------------------
	// store and shared comparator
	// ------------------------------------------------------------------
	logic [CW-1:0]              rd_idx;
	logic [AW-1:0]              rd_addr;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic                       scan_last;
	logic                       lt;
	logic                       le;
	logic [CW-1:0]              less_nxt;
	logic [CW-1:0]              leq_nxt;
	logic [CW-1:0]              rank_lo;
	logic [CW-1:0]              rank_hi;

	assign scan_last = (scan_idx_q == fill_q - CW'(1));

	always_comb begin
		unique case (state_q)
			ST_CAND: rd_idx = cand_idx_q;
			ST_LOAD: rd_idx = '0;
			ST_SCAN: rd_idx = scan_last ? (cand_idx_q + CW'(1)) : (scan_idx_q + CW'(1));
			default: rd_idx = '0;
		endcase
	end

	assign rd_addr = wrap_addr((CW+1)'(oldest_q) + (CW+1)'(rd_idx));

	swmf_window_ram #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (sample_acc),
		.waddr (wr_addr),
		.wdata (sample),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// one signed compare per cycle
	assign lt       = (rd_data < cand_q);
	assign le       = (rd_data <= cand_q);
	assign less_nxt = less_q + CW'(lt);
	assign leq_nxt  = leq_q + CW'(le);

	// ranks of the lower and upper middle entries
	assign rank_lo = (fill_q - CW'(1)) >> 1;
	assign rank_hi = fill_q >> 1;

	// truncated mean of the two middle values
	logic signed [SAMPLE_W:0] mid_sum;
	logic signed [SAMPLE_W:0] mid_adj;
	logic signed [SAMPLE_W:0] mid_half;

	always_comb begin
		mid_sum  = (SAMPLE_W+1)'(lo_q) + (SAMPLE_W+1)'(hi_q);
		// negative odd sums round toward zero
		mid_adj  = mid_sum + (SAMPLE_W+1)'(mid_sum[SAMPLE_W] & mid_sum[0]);
		mid_half = mid_adj >>> 1;
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wsize_q        <= WSIZE_RESET;
			fill_q         <= '0;
			oldest_q       <= '0;
			cand_idx_q     <= '0;
			scan_idx_q     <= '0;
			less_q         <= '0;
			leq_q          <= '0;
			median_valid_q <= 1'b0;
		end else begin
			if (window_size_valid && window_size_ready) begin
				wsize_q <= window_size;
			end
			// a finishing median reloads the output register itself
			if (median_valid_q && !median_stall && state_q != ST_DONE) begin
				median_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (sample_acc) begin
						fill_q     <= fill_nxt;
						oldest_q   <= oldest_nxt;
						cand_idx_q <= '0;
						state_q    <= ST_CAND;
					end
				end
				ST_CAND: begin
					// candidate read in flight
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// candidate on rdata, first scan read in flight
					cand_q     <= rd_data;
					scan_idx_q <= '0;
					less_q     <= '0;
					leq_q      <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					less_q     <= less_nxt;
					leq_q      <= leq_nxt;
					scan_idx_q <= scan_idx_q + CW'(1);
					if (scan_last) begin
						// candidate holds rank k when less <= k < leq
						if (less_nxt <= rank_lo && rank_lo < leq_nxt) begin
							lo_q <= cand_q;
						end
						if (less_nxt <= rank_hi && rank_hi < leq_nxt) begin
							hi_q <= cand_q;
						end
						cand_idx_q <= cand_idx_q + CW'(1);
						if (cand_idx_q == fill_q - CW'(1)) begin
							state_q <= ST_DONE;
						end else begin
							// next candidate read already issued
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: begin
					if (!median_valid_q || !median_stall) begin
						median_q       <= mid_half[SAMPLE_W-1:0];
						median_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_stall      = (state_q != ST_IDLE);
	assign window_size_ready = (state_q == ST_IDLE);
	assign median_valid      = median_valid_q;
	assign median            = median_q;

endmodule
